>>> design/bdec_pkg.sv
// Shared types and constants for the wheel code entry controller.
package bdec_pkg;

	localparam int DIGIT_SLOTS  = 6;
	localparam int SYMBOL_COUNT = 12;

	localparam int CHOICE_W = 4;
	localparam int CURSOR_W = 3;
	localparam int STATUS_W = 2;
	localparam int VALUE_W  = 20;
	localparam int KIND_W   = 2;
	localparam int RND_W    = 4;
	localparam int CNT_W    = 3;
	localparam int MODE_W   = 2;
	localparam int CFG_IDX_W = 3;
	localparam int P10_W    = VALUE_W + 4;

	localparam logic [CHOICE_W-1:0] SYM_BACKSPACE = CHOICE_W'(SYMBOL_COUNT - 2);
	localparam logic [CHOICE_W-1:0] SYM_ENTER     = CHOICE_W'(SYMBOL_COUNT - 1);
	localparam logic [CHOICE_W-1:0] SYM_LAST_DIGIT = 4'd9;

	// divide by ten as multiply by ceil(2^23/10), exact for 20-bit values
	localparam logic [VALUE_W-1:0] DIV10_RECIP = 20'hCCCCD;
	localparam int DIV10_SHIFT = 23;
	localparam int PROD_W = 2 * VALUE_W;

	localparam logic [KIND_W-1:0] KIND_LEFT    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_RIGHT   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLICK   = 2'd2;
	localparam logic [KIND_W-1:0] KIND_RESTART = 2'd3;

	localparam logic [STATUS_W-1:0] ST_ENTERING = 2'd0;
	localparam logic [STATUS_W-1:0] ST_COMPLETE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_ABANDON  = 2'd2;

	localparam logic [MODE_W-1:0] MODE_ZERO   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_CURSOR = 2'd1;

	localparam logic [CFG_IDX_W-1:0] REG_DIGIT_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VALUE_LIMIT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ENTER_EN    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_START_MODE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INVERT      = 3'd4;

	localparam logic [CURSOR_W-1:0] DIGIT_COUNT_RST = CURSOR_W'(DIGIT_SLOTS);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_DIV,
		S_PREP,
		S_NORM,
		S_WHEEL,
		S_OUT
	} bdec_state_t;

	typedef struct packed {
		logic                capture;
		logic                restart;
		logic                finish_set;
		logic [STATUS_W-1:0] finish_code;
		logic                back_step;
		logic                div_write;
		logic                commit;
		logic                load_start;
		logic                normalise;
		logic                wheel_step;
		logic                out_load;
	} bdec_cmd_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              finished;
		logic              choice_bs;
		logic              choice_enter;
		logic              cursor_zero;
		logic              last_digit;
		logic              wheel_hit;
		logic              out_free;
	} bdec_status_t;

endpackage

>>> design/bounded_digit_entry_controller_top.sv
// Top level of the rotary-wheel decimal code entry controller.
// Input channel (in_valid/in_stall) carries one event word: kind (wheel left,
// wheel right, click, restart) and random_digit. Every event yields exactly one
// result word on the output channel (out_valid/out_stall): current_choice,
// cursor, status and entered_value, the state after the event.
// Ignored events and enter/finish clicks go straight to the result; a digit commit
// or restart then loads the start choice and normalises it, and a backspace does
// the same after dividing the prefix by ten through one registered multiply;
// wheel events step one position at a time, trying up to 12, until one is allowed.
// One event is worked at a time; in_stall is high while it is in flight.
// The result sits in an output register: while out_stall holds it, the next
// event is still taken and worked, and its result waits for the register.
// Settings are written on the cfg channel (cfg_ready always high); index 0..4
// selects digit_count, the value limit, enter_enabled, start_mode, invert_wheel.
// Reset: settings return to 6, 0, 0, 0, 0; cursor, choice, value and status
// clear, and no result is pending.
module bounded_digit_entry_controller_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [bdec_pkg::KIND_W-1:0]        kind,
	input  logic [bdec_pkg::RND_W-1:0]         random_digit,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [bdec_pkg::CHOICE_W-1:0]      current_choice,
	output logic [bdec_pkg::CURSOR_W-1:0]      cursor,
	output logic [bdec_pkg::STATUS_W-1:0]      status,
	output logic [bdec_pkg::VALUE_W-1:0]       entered_value,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [bdec_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bdec_pkg::VALUE_W-1:0]       cfg_data
);

	bdec_pkg::bdec_cmd_t    cmd;
	bdec_pkg::bdec_status_t sts;

	assign cfg_ready = 1'b1;

	bdec_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	bdec_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.kind           (kind),
		.random_digit   (random_digit),
		.cfg_we         (cfg_valid & cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.out_stall      (out_stall),
		.out_valid      (out_valid),
		.current_choice (current_choice),
		.cursor         (cursor),
		.status         (status),
		.entered_value  (entered_value)
	);

endmodule

>>> design/bdec_ctrl.sv
// Sequencer for the wheel code entry controller: decodes one event word at a time.
module bdec_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  bdec_pkg::bdec_status_t sts,
	output bdec_pkg::bdec_cmd_t    cmd
);

	bdec_pkg::bdec_state_t state_q, state_d;
	logic [bdec_pkg::CNT_W+1-1:0] cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bdec_pkg::S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	assign in_stall = (state_q != bdec_pkg::S_IDLE);

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		case (state_q)
			bdec_pkg::S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = bdec_pkg::S_DECODE;
				end
			end
			bdec_pkg::S_DECODE: begin
				if (sts.kind == bdec_pkg::KIND_RESTART) begin
					cmd.restart = 1'b1;
					state_d = bdec_pkg::S_PREP;
				end else if (sts.finished) begin
					state_d = bdec_pkg::S_OUT;
				end else if (sts.kind == bdec_pkg::KIND_CLICK) begin
					if (sts.choice_bs) begin
						if (sts.cursor_zero) begin
							cmd.finish_set  = 1'b1;
							cmd.finish_code = bdec_pkg::ST_ABANDON;
							state_d = bdec_pkg::S_OUT;
						end else begin
							cmd.back_step = 1'b1;
							state_d = bdec_pkg::S_DIV;
						end
					end else if (sts.choice_enter) begin
						cmd.finish_set  = 1'b1;
						cmd.finish_code = sts.cursor_zero ? bdec_pkg::ST_ABANDON
						                                  : bdec_pkg::ST_COMPLETE;
						state_d = bdec_pkg::S_OUT;
					end else begin
						cmd.commit = 1'b1;
						if (sts.last_digit) begin
							cmd.finish_set  = 1'b1;
							cmd.finish_code = bdec_pkg::ST_COMPLETE;
							state_d = bdec_pkg::S_OUT;
						end else begin
							state_d = bdec_pkg::S_PREP;
						end
					end
				end else begin
					cnt_d   = '0;
					state_d = bdec_pkg::S_WHEEL;
				end
			end
			bdec_pkg::S_DIV: begin
				cmd.div_write = 1'b1;
				state_d = bdec_pkg::S_PREP;
			end
			bdec_pkg::S_PREP: begin
				// prefix*10 settles during this cycle
				cmd.load_start = 1'b1;
				state_d = bdec_pkg::S_NORM;
			end
			bdec_pkg::S_NORM: begin
				cmd.normalise = 1'b1;
				state_d = bdec_pkg::S_OUT;
			end
			bdec_pkg::S_WHEEL: begin
				cmd.wheel_step = 1'b1;
				if (sts.wheel_hit || cnt_q == 4'(bdec_pkg::SYMBOL_COUNT - 1)) begin
					state_d = bdec_pkg::S_OUT;
				end else begin
					cnt_d = cnt_q + 4'd1;
				end
			end
			bdec_pkg::S_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d = bdec_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = bdec_pkg::S_IDLE;
			end
		endcase
	end

endmodule

>>> design/bdec_dp.sv
// Datapath: settings, entry state, symbol checks, divide by ten and result register.
module bdec_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  bdec_pkg::bdec_cmd_t                cmd,
	output bdec_pkg::bdec_status_t             sts,
	input  logic [bdec_pkg::KIND_W-1:0]        kind,
	input  logic [bdec_pkg::RND_W-1:0]         random_digit,
	input  logic                               cfg_we,
	input  logic [bdec_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bdec_pkg::VALUE_W-1:0]       cfg_data,
	input  logic                               out_stall,
	output logic                               out_valid,
	output logic [bdec_pkg::CHOICE_W-1:0]      current_choice,
	output logic [bdec_pkg::CURSOR_W-1:0]      cursor,
	output logic [bdec_pkg::STATUS_W-1:0]      status,
	output logic [bdec_pkg::VALUE_W-1:0]       entered_value
);

	// settings
	logic [bdec_pkg::CURSOR_W-1:0] digit_count_q;
	logic [bdec_pkg::VALUE_W-1:0]  value_limit_q;
	logic                          enter_en_q;
	logic [bdec_pkg::MODE_W-1:0]   start_mode_q;
	logic                          invert_q;

	// entry state
	logic [bdec_pkg::CURSOR_W-1:0] cursor_q;
	logic [bdec_pkg::CHOICE_W-1:0] choice_q;
	logic [bdec_pkg::VALUE_W-1:0]  prefix_q;
	logic [bdec_pkg::STATUS_W-1:0] finish_q;

	// working registers
	logic [bdec_pkg::KIND_W-1:0]   kind_q;
	logic [bdec_pkg::RND_W-1:0]    rnd_q;
	logic [bdec_pkg::P10_W-1:0]    p10_q;
	logic [bdec_pkg::PROD_W-1:0]   prod_q;
	logic                          out_valid_q;

	logic [bdec_pkg::CURSOR_W-1:0] digits_req;
	logic [bdec_pkg::CHOICE_W-1:0] start_val;
	logic [bdec_pkg::CHOICE_W-1:0] norm_val;
	logic [bdec_pkg::CHOICE_W-1:0] step_val;
	logic                          fwd;

	function automatic logic sym_ok(input logic [bdec_pkg::CHOICE_W-1:0] s,
	                                input logic [bdec_pkg::P10_W-1:0] p10,
	                                input logic [bdec_pkg::VALUE_W-1:0] maxv,
	                                input logic en);
		logic [bdec_pkg::P10_W:0] sum;
		logic ok;
		sum = {1'b0, p10} + (bdec_pkg::P10_W+1)'(s);
		if (s <= bdec_pkg::SYM_LAST_DIGIT) begin
			ok = (maxv == '0) || (sum <= (bdec_pkg::P10_W+1)'(maxv));
		end else if (s == bdec_pkg::SYM_BACKSPACE) begin
			ok = 1'b1;
		end else if (s == bdec_pkg::SYM_ENTER) begin
			ok = en;
		end else begin
			ok = 1'b0;
		end
		return ok;
	endfunction

	assign digits_req = (digit_count_q == '0 || digit_count_q > bdec_pkg::DIGIT_COUNT_RST)
	                    ? bdec_pkg::DIGIT_COUNT_RST : digit_count_q;

	always_comb begin
		if (start_mode_q == bdec_pkg::MODE_ZERO) begin
			start_val = '0;
		end else if (start_mode_q == bdec_pkg::MODE_CURSOR) begin
			start_val = {1'b0, cursor_q};
		end else begin
			start_val = (rnd_q <= bdec_pkg::SYM_LAST_DIGIT) ? rnd_q : '0;
		end
	end

	// digits allowed form a run from zero, so the lowest allowed symbol is 0 or backspace
	always_comb begin
		if (sym_ok(choice_q, p10_q, value_limit_q, enter_en_q)) begin
			norm_val = choice_q;
		end else if (enter_en_q && cursor_q != '0) begin
			norm_val = bdec_pkg::SYM_ENTER;
		end else if (sym_ok('0, p10_q, value_limit_q, enter_en_q)) begin
			norm_val = '0;
		end else begin
			norm_val = bdec_pkg::SYM_BACKSPACE;
		end
	end

	assign fwd = (kind_q == bdec_pkg::KIND_RIGHT) ^ invert_q;

	always_comb begin
		if (fwd) begin
			step_val = (choice_q == bdec_pkg::SYM_ENTER) ? '0 : choice_q + 4'd1;
		end else begin
			step_val = (choice_q == '0) ? bdec_pkg::SYM_ENTER : choice_q - 4'd1;
		end
	end

	always_comb begin
		sts.kind         = kind_q;
		sts.finished     = (finish_q != bdec_pkg::ST_ENTERING);
		sts.choice_bs    = (choice_q == bdec_pkg::SYM_BACKSPACE);
		sts.choice_enter = (choice_q == bdec_pkg::SYM_ENTER);
		sts.cursor_zero  = (cursor_q == '0);
		sts.last_digit   = ({1'b0, cursor_q} + 4'd1) >= {1'b0, digits_req};
		sts.wheel_hit    = sym_ok(step_val, p10_q, value_limit_q, enter_en_q);
		sts.out_free     = !out_valid_q || !out_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_count_q <= bdec_pkg::DIGIT_COUNT_RST;
			value_limit_q <= '0;
			enter_en_q    <= 1'b0;
			start_mode_q  <= '0;
			invert_q      <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				bdec_pkg::REG_DIGIT_COUNT: digit_count_q <= cfg_data[bdec_pkg::CURSOR_W-1:0];
				bdec_pkg::REG_VALUE_LIMIT: value_limit_q <= cfg_data;
				bdec_pkg::REG_ENTER_EN:    enter_en_q    <= cfg_data[0];
				bdec_pkg::REG_START_MODE:  start_mode_q  <= cfg_data[bdec_pkg::MODE_W-1:0];
				bdec_pkg::REG_INVERT:      invert_q      <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
			choice_q <= '0;
			prefix_q <= '0;
			finish_q <= bdec_pkg::ST_ENTERING;
		end else begin
			if (cmd.restart) begin
				cursor_q <= '0;
				prefix_q <= '0;
				finish_q <= bdec_pkg::ST_ENTERING;
			end
			if (cmd.finish_set) begin
				finish_q <= cmd.finish_code;
			end
			if (cmd.back_step) begin
				cursor_q <= cursor_q - 3'd1;
			end
			if (cmd.div_write) begin
				prefix_q <= bdec_pkg::VALUE_W'(prod_q[bdec_pkg::PROD_W-1:bdec_pkg::DIV10_SHIFT]);
			end
			if (cmd.commit) begin
				prefix_q <= p10_q[bdec_pkg::VALUE_W-1:0] + bdec_pkg::VALUE_W'(choice_q);
				cursor_q <= cursor_q + 3'd1;
			end
			if (cmd.load_start) begin
				choice_q <= start_val;
			end
			if (cmd.normalise) begin
				choice_q <= norm_val;
			end
			if (cmd.wheel_step) begin
				choice_q <= step_val;
			end
		end
	end

	// payload and work registers
	always_ff @(posedge clk) begin
		p10_q  <= {1'b0, prefix_q, 3'b000} + {3'b000, prefix_q, 1'b0};
		prod_q <= bdec_pkg::PROD_W'(prefix_q) * bdec_pkg::PROD_W'(bdec_pkg::DIV10_RECIP);
		if (cmd.capture) begin
			kind_q <= kind;
			rnd_q  <= random_digit;
		end
		if (cmd.out_load) begin
			current_choice <= choice_q;
			cursor         <= cursor_q;
			status         <= finish_q;
			entered_value  <= prefix_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule
